@@ hw/rtl/ipgm_pkg.sv @@
`default_nettype none
package ipgm_pkg;

  // divider geometry: numerator bits, divisor bits, partial remainder bits, kept quotient bits
  localparam int NUM_W = 62;
  localparam int DEN_W = 40;
  localparam int REM_W = 41;
  localparam int Q_W   = 48;

  // register indexes
  localparam logic [2:0] REG_FOCAL  = 3'd0;
  localparam logic [2:0] REG_SIN_T  = 3'd1;
  localparam logic [2:0] REG_COS_T  = 3'd2;
  localparam logic [2:0] REG_SIN_P  = 3'd3;
  localparam logic [2:0] REG_COS_P  = 3'd4;
  localparam logic [2:0] REG_CAM_H  = 3'd5;
  localparam logic [2:0] REG_OFFSET = 3'd6;
  localparam logic [2:0] REG_M2P    = 3'd7;

  localparam logic signed [65:0] MAX48 = 66'sd140737488355327;
  localparam logic signed [65:0] MIN48 = -66'sd140737488355328;
  localparam logic signed [65:0] MAX32 = 66'sd2147483647;
  localparam logic signed [65:0] MIN32 = -66'sd2147483648;

  // side information carried through the divider
  typedef struct packed {
    logic inval;
    logic neg_y;
    logic neg_x;
  } div_tag_t;

  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    logic signed [47:0] r;
    if (v > MAX48) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (v < MIN48) begin
      r = 48'sh8000_0000_0000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > MAX32) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < MIN32) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ipgm_div.sv @@
`default_nettype none
// three-lane restoring divider, one quotient bit per stage, shared divisor
module ipgm_div (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    en,
  input  wire logic                                    in_vld,
  input  wire ipgm_pkg::div_tag_t                      in_tag,
  input  wire logic [2:0][ipgm_pkg::NUM_W-1:0]         num,
  input  wire logic [ipgm_pkg::DEN_W-1:0]              den,
  output logic                                         out_vld,
  output ipgm_pkg::div_tag_t                           out_tag,
  output logic [2:0][ipgm_pkg::Q_W-1:0]                quo,
  output logic [2:0]                                   ovf
);
  localparam int NW = ipgm_pkg::NUM_W;
  localparam int RW = ipgm_pkg::REM_W;
  localparam int QW = ipgm_pkg::Q_W;

  logic                         vld [NW];
  ipgm_pkg::div_tag_t           tag [NW];
  logic [ipgm_pkg::DEN_W-1:0]   dv  [NW];
  logic [2:0][NW-1:0]           nm  [NW];
  logic [2:0][RW-1:0]           rm  [NW];
  logic [2:0][QW-1:0]           qq  [NW];
  logic [2:0]                   of  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic                       p_vld;
    ipgm_pkg::div_tag_t         p_tag;
    logic [ipgm_pkg::DEN_W-1:0] p_dv;
    logic [2:0][NW-1:0]         p_nm;
    logic [2:0][RW-1:0]         p_rm;
    logic [2:0][QW-1:0]         p_qq;
    logic [2:0]                 p_of;
    logic [2:0][RW-1:0]         rm_next;
    logic [2:0][QW-1:0]         qq_next;
    logic [2:0]                 of_next;

    if (k == 0) begin : g_first
      assign p_vld = in_vld;
      assign p_tag = in_tag;
      assign p_dv  = den;
      assign p_nm  = num;
      assign p_rm  = '0;
      assign p_qq  = '0;
      assign p_of  = '0;
    end else begin : g_rest
      assign p_vld = vld[k-1];
      assign p_tag = tag[k-1];
      assign p_dv  = dv[k-1];
      assign p_nm  = nm[k-1];
      assign p_rm  = rm[k-1];
      assign p_qq  = qq[k-1];
      assign p_of  = of[k-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        logic [RW-1:0] sh;
        logic          ge;
        sh = {p_rm[l][RW-2:0], p_nm[l][NW-1]};
        ge = (sh >= {1'b0, p_dv});
        rm_next[l] = ge ? (sh - {1'b0, p_dv}) : sh;
        qq_next[l] = {p_qq[l][QW-2:0], ge};
        of_next[l] = p_of[l] | p_qq[l][QW-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag[k] <= p_tag;
        dv[k]  <= p_dv;
        nm[k]  <= {p_nm[2][NW-2:0], 1'b0, p_nm[1][NW-2:0], 1'b0, p_nm[0][NW-2:0], 1'b0};
        rm[k]  <= rm_next;
        qq[k]  <= qq_next;
        of[k]  <= of_next;
      end
    end
  end

  assign out_vld = vld[NW-1];
  assign out_tag = tag[NW-1];
  assign quo     = qq[NW-1];
  assign ovf     = of[NW-1];
endmodule
`default_nettype wire

@@ hw/rtl/inverse_perspective_ground_map.sv @@
`default_nettype none
// channel  | dir | handshake          | payload
// s_*      | in  | s_tvalid/s_tready  | s_tdata: pixel_x, pixel_y, plane_height
// m_*      | out | m_tvalid/m_tready  | m_tdata: world x/y/z, image u/v; m_tuser: flags
// cfg_*    | in  | cfg_we             | cfg_index, cfg_data
//
// one item per clock while the pipeline is not stalled; 2 front stages, 62 divider stages, 8 back stages
// the divider is one quotient bit per stage over a 62-bit numerator, which sets the depth
// rst clears the valid bits and restores the register reset values
// a stall freezes the whole pipeline: s_tready follows !m_tvalid || m_tready
module inverse_perspective_ground_map #(
  parameter int CAM_WIDTH   = 640,
  parameter int CAM_HEIGHT  = 480,
  parameter int GROUND_COLS = 1024,
  parameter int GROUND_ROWS = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [47:0]  s_tdata,   // pixel_x[11:0], pixel_y[23:12], plane_height[47:24]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [159:0]      m_tdata,   // world_x, world_y, world_z, image_u, image_v (32b each)
  output logic [1:0]        m_tuser,   // valid_res[0], in_ground[1]
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [23:0]  cfg_data
);
  localparam logic signed [13:0] CW     = 14'(CAM_WIDTH);
  localparam logic signed [13:0] CH     = 14'(CAM_HEIGHT);
  localparam logic signed [33:0] U_LIM  = 34'(GROUND_COLS) <<< 16;
  localparam logic signed [33:0] V_LIM  = 34'(GROUND_ROWS) <<< 16;

  // configuration registers
  logic [23:0]        focal;
  logic signed [15:0] sin_t, cos_t, sin_p, cos_p;
  logic [23:0]        cam_h, offset, m2p;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal  <= 24'd256000;
      sin_t  <= 16'sd0;
      cos_t  <= 16'sd16384;
      sin_p  <= 16'sd0;
      cos_p  <= 16'sd16384;
      cam_h  <= 24'd655360;
      offset <= 24'd0;
      m2p    <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipgm_pkg::REG_FOCAL:  focal  <= cfg_data;
        ipgm_pkg::REG_SIN_T:  sin_t  <= cfg_data[15:0];
        ipgm_pkg::REG_COS_T:  cos_t  <= cfg_data[15:0];
        ipgm_pkg::REG_SIN_P:  sin_p  <= cfg_data[15:0];
        ipgm_pkg::REG_COS_P:  cos_p  <= cfg_data[15:0];
        ipgm_pkg::REG_CAM_H:  cam_h  <= cfg_data;
        ipgm_pkg::REG_OFFSET: offset <= cfg_data;
        ipgm_pkg::REG_M2P:    m2p    <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: the whole pipe moves unless a held result blocks it
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: centred pixel offsets (half-pixel units), first products, height difference
  logic signed [13:0] dx2, dy2;
  assign dx2 = $signed({1'b0, s_tdata[11:0], 1'b0}) - CW;
  assign dy2 = $signed({1'b0, s_tdata[23:12], 1'b0}) - CH;

  logic               v1;
  logic signed [13:0] s1_dx2, s1_dy2;
  logic signed [40:0] s1_fst;
  logic signed [29:0] s1_dyc;
  logic signed [24:0] s1_h;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx2 <= dx2;
      s1_dy2 <= dy2;
      s1_fst <= $signed({1'b0, focal}) * sin_t;
      s1_dyc <= dy2 * cos_t;
      s1_h   <= $signed({1'b0, cam_h}) - $signed({1'b0, s_tdata[47:24]});
    end
  end

  // stage 2: ray denominator, validity, numerator magnitudes
  logic signed [41:0] d_full;
  logic [13:0]        adx, ady;
  assign d_full = 42'(s1_fst) + (42'(s1_dyc) <<< 7);
  assign adx    = s1_dx2[13] ? 14'(-s1_dx2) : s1_dx2;
  assign ady    = s1_dy2[13] ? 14'(-s1_dy2) : s1_dy2;

  logic                    v2;
  logic [ipgm_pkg::DEN_W-1:0] s2_den;
  logic [36:0]             s2_mx, s2_my;
  logic [47:0]             s2_mz;
  ipgm_pkg::div_tag_t      s2_tag;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_den       <= d_full[ipgm_pkg::DEN_W-1:0];
      s2_mx        <= adx[12:0] * s1_h[23:0];
      s2_my        <= ady[12:0] * s1_h[23:0];
      s2_mz        <= focal * s1_h[23:0];
      s2_tag.inval <= s1_h[24] || (d_full <= 42'sd0);
      s2_tag.neg_x <= s1_dx2[13];
      s2_tag.neg_y <= s1_dy2[13];
    end
  end

  // divider: ground vector magnitudes h*dx/d, h*dy/d, h*f/d
  logic [2:0][ipgm_pkg::NUM_W-1:0] dnum;
  assign dnum[0] = {4'd0, s2_mx, 21'd0};
  assign dnum[1] = {4'd0, s2_my, 21'd0};
  assign dnum[2] = {s2_mz, 14'd0};

  logic                          vd;
  ipgm_pkg::div_tag_t            d_tag;
  logic [2:0][ipgm_pkg::Q_W-1:0] d_quo;
  logic [2:0]                    d_ovf;

  ipgm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v2),
    .in_tag  (s2_tag),
    .num     (dnum),
    .den     (s2_den),
    .out_vld (vd),
    .out_tag (d_tag),
    .quo     (d_quo),
    .ovf     (d_ovf)
  );

  // stage A: apply sign, saturate the ground vector to 48 bits
  logic signed [47:0] gq [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic big;
      logic neg;
      big = d_ovf[l] | d_quo[l][47];
      neg = (l == 0) ? d_tag.neg_x : ((l == 1) ? d_tag.neg_y : 1'b0);
      if (neg) begin
        gq[l] = big ? 48'sh8000_0000_0000 : 48'(-$signed({1'b0, d_quo[l]}));
      end else begin
        gq[l] = big ? 48'sh7FFF_FFFF_FFFF : $signed(d_quo[l]);
      end
    end
  end

  logic               va;
  logic               a_inval;
  logic signed [47:0] a_gx, a_gy, a_gz;
  always_ff @(posedge clk) begin
    if (en) begin
      a_inval <= d_tag.inval;
      a_gx    <= gq[0];
      a_gy    <= gq[1];
      a_gz    <= gq[2];
    end
  end

  // stage B: tilt products
  logic               vb, b_inval;
  logic signed [47:0] b_gx;
  logic signed [63:0] b_cgy, b_sgz, b_cgz, b_sgy;
  always_ff @(posedge clk) begin
    if (en) begin
      b_inval <= a_inval;
      b_gx    <= a_gx;
      b_cgy   <= cos_t * a_gy;
      b_sgz   <= sin_t * a_gz;
      b_cgz   <= cos_t * a_gz;
      b_sgy   <= sin_t * a_gy;
    end
  end

  // stage C: tilt sums, round half up, saturate
  logic               vc, c_inval;
  logic signed [47:0] c_ax, c_ay, c_az;
  always_ff @(posedge clk) begin
    if (en) begin
      c_inval <= b_inval;
      c_ax    <= b_gx;
      c_ay    <= ipgm_pkg::sat48((66'(b_cgy) + 66'(b_sgz) + 66'sd8192) >>> 14);
      c_az    <= ipgm_pkg::sat48((66'(b_cgz) - 66'(b_sgy) + 66'sd8192) >>> 14);
    end
  end

  // stage D: pan products
  logic               vdd, e1_inval;
  logic signed [47:0] e1_ay;
  logic signed [63:0] e1_cax, e1_saz, e1_caz, e1_sax;
  always_ff @(posedge clk) begin
    if (en) begin
      e1_inval <= c_inval;
      e1_ay    <= c_ay;
      e1_cax   <= cos_p * c_ax;
      e1_saz   <= sin_p * c_az;
      e1_caz   <= cos_p * c_az;
      e1_sax   <= sin_p * c_ax;
    end
  end

  // stage E: pan sums, round half up, saturate
  logic               ve, e_inval;
  logic signed [47:0] e_wx, e_wy, e_wz;
  always_ff @(posedge clk) begin
    if (en) begin
      e_inval <= e1_inval;
      e_wy    <= e1_ay;
      e_wx    <= ipgm_pkg::sat48((66'(e1_cax) + 66'(e1_saz) + 66'sd8192) >>> 14);
      e_wz    <= ipgm_pkg::sat48((66'(e1_caz) - 66'(e1_sax) + 66'sd8192) >>> 14);
    end
  end

  // stage F: ground offset on x, world values to 32 bits
  logic               vf, f_inval;
  logic signed [31:0] f_wx, f_wy, f_wz;
  always_ff @(posedge clk) begin
    if (en) begin
      f_inval <= e_inval;
      f_wx    <= ipgm_pkg::sat32(66'(e_wx) + 66'($signed({1'b0, offset})));
      f_wy    <= ipgm_pkg::sat32(66'(e_wy));
      f_wz    <= ipgm_pkg::sat32(66'(e_wz));
    end
  end

  // stage G: scale to ground image pixels
  logic               vg, g_inval;
  logic signed [31:0] g_wx, g_wy, g_wz;
  logic signed [56:0] g_pu, g_pv;
  always_ff @(posedge clk) begin
    if (en) begin
      g_inval <= f_inval;
      g_wx    <= f_wx;
      g_wy    <= f_wy;
      g_wz    <= f_wz;
      g_pu    <= f_wz * $signed({1'b0, m2p});
      g_pv    <= f_wx * $signed({1'b0, m2p});
    end
  end

  // stage H (output register): round, saturate, range flag, zero invalid items
  logic signed [31:0] img_u, img_v;
  logic               inside_img;
  assign img_u      = ipgm_pkg::sat32((66'(g_pu) + 66'sd32768) >>> 16);
  assign img_v      = ipgm_pkg::sat32((66'(g_pv) + 66'sd32768) >>> 16);
  assign inside_img = !img_u[31] && (34'(img_u) < U_LIM) &&
                      !img_v[31] && (34'(img_v) < V_LIM);

  always_ff @(posedge clk) begin
    if (en) begin
      if (g_inval) begin
        m_tdata <= '0;
        m_tuser <= 2'b00;
      end else begin
        m_tdata <= {img_v, img_u, g_wz, g_wy, g_wx};
        m_tuser <= {inside_img, 1'b1};
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      vdd      <= 1'b0;
      ve       <= 1'b0;
      vf       <= 1'b0;
      vg       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1       <= s_tvalid;
      v2       <= v1;
      va       <= vd;
      vb       <= va;
      vc       <= vb;
      vdd      <= vc;
      ve       <= vdd;
      vf       <= ve;
      vg       <= vf;
      m_tvalid <= vg;
    end
  end

`ifndef NO_ASSERTIONS
  // an invalid result carries only zeros
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
    else $error("invalid result with non-zero payload");

  // the ground flag needs a valid point
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("in_ground set on invalid result");

  // nothing leaves the pipe in the cycle after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");
`endif
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // block geometry, left at the block's defaults
  localparam int  CAM_W    = 640;
  localparam int  CAM_H    = 480;
  localparam int  COLS     = 1024;
  localparam int  ROWS     = 1024;
  localparam int  LATENCY  = 72;
  localparam int  WD_LIMIT = 5000;
  localparam longint LIM48 = 64'sh7FFF_FFFF_FFFF;
  localparam longint LIM32 = 64'sh7FFF_FFFF;

  typedef struct packed {
    logic [1:0]   flags;   // valid_res[0], in_ground[1]
    logic [159:0] coords;  // world x/y/z, image u/v
  } ground_point_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;   // pixel_x[11:0], pixel_y[23:12], plane_height[47:24]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;        // world_x, world_y, world_z, image_u, image_v
  logic [1:0]   m_tuser;        // valid_res[0], in_ground[1]
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [23:0]  cfg_data = '0;

  // own copy of the register file
  longint focal, sin_t, cos_t, sin_p, cos_p, cam_h, offset, m2p;

  logic [47:0]   pixel_queue[$];
  ground_point_t ground_queue[$];
  int errors = 0;
  int results_seen = 0;

  always #2 clk = ~clk;

  inverse_perspective_ground_map u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .m_tuser, .cfg_we, .cfg_index, .cfg_data
  );

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim - 1) return -lim - 1;
    return v;
  endfunction

  // round half up from Q.30 to Q.16
  function automatic longint rnd14(longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic ground_point_t project_pixel(logic [47:0] item);
    ground_point_t r;
    longint px, py, obj, dx2, dy2, d, h, gx, gy, gz, ay, az, wx, wy, wz, u, v;
    r = '0;
    px  = longint'(item[11:0]);
    py  = longint'(item[23:12]);
    obj = longint'(item[47:24]);
    dx2 = 2 * px - CAM_W;
    dy2 = 2 * py - CAM_H;
    d   = focal * sin_t + dy2 * cos_t * 128;
    // ray misses the plane or camera sits below it
    if (d <= 0 || cam_h < obj) return r;
    h  = cam_h - obj;
    // signed division truncates towards zero, as the block does
    gx = clip((dx2 * h * 64'sd2097152) / d, LIM48);
    gy = clip((dy2 * h * 64'sd2097152) / d, LIM48);
    gz = clip((focal * h * 64'sd16384) / d, LIM48);
    ay = clip(rnd14(cos_t * gy + sin_t * gz), LIM48);
    az = clip(rnd14(cos_t * gz - sin_t * gy), LIM48);
    wx = clip(rnd14(cos_p * gx + sin_p * az), LIM48);
    wy = ay;
    wz = clip(rnd14(cos_p * az - sin_p * gx), LIM48);
    wx = clip(wx + offset, LIM32);
    wy = clip(wy, LIM32);
    wz = clip(wz, LIM32);
    u  = clip((wz * m2p + 64'sd32768) >>> 16, LIM32);
    v  = clip((wx * m2p + 64'sd32768) >>> 16, LIM32);
    r.flags[0] = 1'b1;
    r.flags[1] = (u >= 0 && u < (longint'(COLS) << 16) && v >= 0 && v < (longint'(ROWS) << 16));
    r.coords = {v[31:0], u[31:0], wz[31:0], wy[31:0], wx[31:0]};
    return r;
  endfunction

  // one register write per clock; predictor copy follows at once
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      ipgm_pkg::REG_FOCAL:  focal  = longint'(val);
      ipgm_pkg::REG_SIN_T:  sin_t  = longint'($signed(val[15:0]));
      ipgm_pkg::REG_COS_T:  cos_t  = longint'($signed(val[15:0]));
      ipgm_pkg::REG_SIN_P:  sin_p  = longint'($signed(val[15:0]));
      ipgm_pkg::REG_COS_P:  cos_p  = longint'($signed(val[15:0]));
      ipgm_pkg::REG_CAM_H:  cam_h  = longint'(val);
      ipgm_pkg::REG_OFFSET: offset = longint'(val);
      ipgm_pkg::REG_M2P:    m2p    = longint'(val);
      default: ;
    endcase
  endtask

  task automatic write_all(logic [23:0] f, logic [15:0] st, logic [15:0] ct, logic [15:0] sp,
                           logic [15:0] cp, logic [23:0] ch, logic [23:0] go, logic [23:0] mp);
    write_reg(ipgm_pkg::REG_FOCAL, f);
    write_reg(ipgm_pkg::REG_SIN_T, {{8{st[15]}}, st});
    write_reg(ipgm_pkg::REG_COS_T, {{8{ct[15]}}, ct});
    write_reg(ipgm_pkg::REG_SIN_P, {{8{sp[15]}}, sp});
    write_reg(ipgm_pkg::REG_COS_P, {{8{cp[15]}}, cp});
    write_reg(ipgm_pkg::REG_CAM_H, ch);
    write_reg(ipgm_pkg::REG_OFFSET, go);
    write_reg(ipgm_pkg::REG_M2P, mp);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // trig value in Q1.14, full range
  function automatic logic [15:0] rand_trig();
    int t;
    t = int'($urandom_range(0, 32768)) - 16384;
    return t[15:0];
  endfunction

  function automatic logic [47:0] pack_pixel(int x, int y, logic [23:0] obj);
    logic [11:0] xx, yy;
    xx = x[11:0];
    yy = y[11:0];
    return {obj, yy, xx};
  endfunction

  // wait until every item is sent and every result checked, then let the pipeline settle
  task automatic drain();
    do begin
      @(negedge clk);
    end while (pixel_queue.size() != 0 || s_tvalid || ground_queue.size() != 0);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic random_pixels(int n);
    logic [23:0] obj;
    int x, y;
    for (int i = 0; i < n; i++) begin
      // mostly pixels inside the frame and planes under the camera
      if ($urandom_range(0, 9) < 8) begin
        x = $urandom_range(0, CAM_W - 1);
        y = $urandom_range(0, CAM_H - 1);
      end else begin
        x = $urandom_range(0, 4095);
        y = $urandom_range(0, 4095);
      end
      case ($urandom_range(0, 9))
        0:       obj = 24'($urandom);
        1:       obj = cam_h[23:0];
        default: obj = (cam_h == 0) ? 24'd0 : 24'($urandom_range(0, int'(cam_h)));
      endcase
      pixel_queue.push_back(pack_pixel(x, y, obj));
    end
  endtask

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        ground_queue.push_back(project_pixel(s_tdata));
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pixel_queue.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
            gap_left   = $urandom_range(0, 1) == 0 ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern changes every so often, plus one long hold-off
  int mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit held = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      if (!held && results_seen >= 600) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 1) == 1);
          2:       m_tready <= ($urandom_range(0, 7) == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    ground_point_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (ground_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result flags=%b data=%h", m_tuser, m_tdata);
      end else begin
        want = ground_queue.pop_front();
        if (want.flags !== m_tuser || want.coords !== m_tdata) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch flags exp=%b got=%b", want.flags, m_tuser);
            for (int k = 0; k < 5; k++) begin
              $display("  word %0d exp=%h got=%h", k, want.coords[32*k +: 32],
                       m_tdata[32*k +: 32]);
            end
          end
        end
      end
    end
  end

  // watchdog: cycles without progress while work is outstanding
  int stuck = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (pixel_queue.size() == 0 && ground_queue.size() == 0 && !s_tvalid)) begin
      stuck <= 0;
    end else if (stuck >= WD_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    logic [23:0] ch;
    focal = 256000; sin_t = 0; cos_t = 16384; sin_p = 0; cos_p = 16384;
    cam_h = 655360; offset = 0; m2p = 65536;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed items at the reset settings: no tilt, so rows above centre miss
    pixel_queue.push_back(pack_pixel(0, 0, 24'd0));
    pixel_queue.push_back(pack_pixel(4095, 4095, 24'd0));
    pixel_queue.push_back(pack_pixel(320, 240, 24'd0));        // horizon row, d is zero
    pixel_queue.push_back(pack_pixel(320, 241, 24'd0));
    pixel_queue.push_back(pack_pixel(639, 479, 24'd0));
    pixel_queue.push_back(pack_pixel(0, 479, 24'd327680));
    pixel_queue.push_back(pack_pixel(100, 300, 24'd655360));    // equal heights
    pixel_queue.push_back(pack_pixel(100, 300, 24'd655361));    // camera below plane
    pixel_queue.push_back(pack_pixel(100, 300, 24'hFFFFFF));
    pixel_queue.push_back(pack_pixel(4095, 241, 24'd0));
    pixel_queue.push_back(pack_pixel(0, 4095, 24'd655359));
    drain();

    // tilted down by 30 degrees, ground image offset
    write_all(24'd256000, 16'sd8192, 16'sd14189, 16'sd0, 16'sd16384, 24'd655360,
              24'd5000000, 24'd1000000);
    pixel_queue.push_back(pack_pixel(0, 0, 24'd0));
    pixel_queue.push_back(pack_pixel(639, 479, 24'd0));
    pixel_queue.push_back(pack_pixel(320, 240, 24'd100));
    pixel_queue.push_back(pack_pixel(4095, 4095, 24'd0));
    drain();

    // extremes: everything at full scale, tilt sine at +1 and cosine at -1, negative pan
    write_all(24'hFFFFFF, 16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 24'hFFFFFF,
              24'hFFFFFF, 24'hFFFFFF);
    pixel_queue.push_back(pack_pixel(0, 0, 24'd0));
    pixel_queue.push_back(pack_pixel(4095, 4095, 24'd0));
    pixel_queue.push_back(pack_pixel(4095, 0, 24'hFFFFFF));
    pixel_queue.push_back(pack_pixel(320, 240, 24'd1));
    drain();

    // zero focal length, zero height, zero scale
    write_all(24'd0, -16'sd16384, 16'sd16384, 16'sd16384, 16'sd0, 24'd0, 24'd0, 24'd0);
    pixel_queue.push_back(pack_pixel(320, 479, 24'd0));
    pixel_queue.push_back(pack_pixel(320, 0, 24'd0));
    pixel_queue.push_back(pack_pixel(4095, 4095, 24'd0));
    drain();

    // random settings; tilt kept mostly downwards so most rays hit
    for (int ph = 0; ph < 10; ph++) begin
      ch = (ph % 3 == 0) ? 24'($urandom) : 24'($urandom_range(0, 2000000));
      write_all($urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(20000, 600000)),
                $urandom_range(0, 3) == 0 ? rand_trig() : 16'($urandom_range(0, 16384)),
                rand_trig(), rand_trig(), rand_trig(), ch,
                $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 3000000)),
                $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 400000)));
      random_pixels(190);
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
